// ===== sv/fwfc_pkg.sv =====
package fwfc_pkg;

    // Field and register widths.
    localparam int RANGE_W   = 13;
    localparam int SPEED_W   = 10;
    localparam int ACT_W     = 2;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    // A clamped sonar range never exceeds 1600, so 11 bits hold it.
    localparam int CLAMP_W = 11;
    localparam logic [RANGE_W-1:0] SONAR_CLAMP = 13'd1600;

    // Membership arithmetic in signed Q2.14.
    localparam int Q_FRAC    = 14;
    localparam int MEMB_W    = 15;
    localparam int RULE_W    = 16;
    localparam int RULES     = 4;
    localparam int MEM_STEPS = MEMB_W;
    localparam int MEM_REM_W = RANGE_W + MEMB_W - 1;
    localparam logic [MEMB_W-1:0] Q_MAX = 15'h7fff;
    localparam logic signed [RULE_W-1:0] Q_ONE = 16'sd16384;

    // Weighted sum and speed division widths.
    localparam int PROD_W    = 27;
    localparam int SUM_W     = 18;
    localparam int DIV_W     = SUM_W - 1;
    localparam int N_W       = 28;
    localparam int NUM_W     = 30;
    localparam int SPD_REM_W = NUM_W - 1;
    localparam int SPD_STEPS = SPEED_W;

    // Edges from the accepting edge to the edge that takes the result.
    localparam int PIPE_LATENCY = MEM_STEPS + SPD_STEPS + 6;

    // Action codes of a result.
    localparam logic [ACT_W-1:0] ACT_FUZZY = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RF    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LF    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_ZERO  = 2'd3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_FOLLOW_SIDE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NOMINAL_SPEED   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AVOID_DISTANCE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIDE_FULL_SCALE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIAG_FULL_SCALE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OUTER_WEIGHT    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INNER_WEIGHT    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT     = 3'd7;

    // Register reset values.
    localparam logic                 RST_FOLLOW_SIDE     = 1'b0;
    localparam logic [SPEED_W-1:0]   RST_NOMINAL_SPEED   = 10'd600;
    localparam logic [RANGE_W-1:0]   RST_AVOID_DISTANCE  = 13'd1200;
    localparam logic [RANGE_W-1:0]   RST_SIDE_FULL_SCALE = 13'd1200;
    localparam logic [RANGE_W-1:0]   RST_DIAG_FULL_SCALE = 13'd1566;
    localparam logic [SPEED_W-1:0]   RST_OUTER_WEIGHT    = 10'd200;
    localparam logic [SPEED_W-1:0]   RST_INNER_WEIGHT    = 10'd100;
    localparam logic [SPEED_W-1:0]   RST_SPEED_LIMIT     = 10'd800;

    // Clamp a raw sonar range to the sonar ceiling.
    function automatic logic [CLAMP_W-1:0] clamp_range(input logic [RANGE_W-1:0] r);
        logic [CLAMP_W-1:0] v;
        v = (r > SONAR_CLAMP) ? SONAR_CLAMP[CLAMP_W-1:0] : r[CLAMP_W-1:0];
        return v;
    endfunction

    // Signed minimum of two rule strengths.
    function automatic logic signed [RULE_W-1:0] rule_min(
        input logic signed [RULE_W-1:0] a,
        input logic signed [RULE_W-1:0] b
    );
        logic signed [RULE_W-1:0] m;
        m = (a < b) ? a : b;
        return m;
    endfunction

    // Unsigned minimum of two speeds.
    function automatic logic [SPEED_W-1:0] speed_min(
        input logic [SPEED_W-1:0] a,
        input logic [SPEED_W-1:0] b
    );
        logic [SPEED_W-1:0] m;
        m = (a < b) ? a : b;
        return m;
    endfunction

    // Final wheel speed from the quotient and its sign and overflow flags.
    function automatic logic [SPEED_W-1:0] fuzzy_speed(
        input logic               neg,
        input logic               sat,
        input logic [SPEED_W-1:0] quo,
        input logic [SPEED_W-1:0] lim
    );
        logic [SPEED_W-1:0] s;
        if (neg)
        begin
            s = '0;
        end
        else if (sat)
        begin
            s = lim;
        end
        else
        begin
            s = speed_min(quo, lim);
        end
        return s;
    endfunction

endpackage

// ===== sv/fuzzy_wall_follow_controller_unit.sv =====
// Throughput: one control tick per cycle; busy is never raised and the pipeline never stalls.
// The depth is set by two restoring dividers, one quotient bit per stage: 15 stages for
// the memberships and 10 for the wheel speeds; the receiver cannot stall, so done is a strobe.
// Reset clears the pipeline valid bits and the done strobe, and loads the registers' defaults.
module fuzzy_wall_follow_controller_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fwfc_pkg::ADDR_W-1:0]    paddr,
    input  logic [fwfc_pkg::DATA_W-1:0]    pwdata,
    output logic [fwfc_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic [fwfc_pkg::RANGE_W-1:0]   left_side_range,
    input  logic [fwfc_pkg::RANGE_W-1:0]   left_diag_range,
    input  logic [fwfc_pkg::RANGE_W-1:0]   left_front_range,
    input  logic [fwfc_pkg::RANGE_W-1:0]   right_front_range,
    input  logic [fwfc_pkg::RANGE_W-1:0]   right_diag_range,
    input  logic [fwfc_pkg::RANGE_W-1:0]   right_side_range,
    output logic                           done,
    output logic [fwfc_pkg::SPEED_W-1:0]   left_speed,
    output logic [fwfc_pkg::SPEED_W-1:0]   right_speed,
    output logic [fwfc_pkg::ACT_W-1:0]     action
);

    localparam int ML = fwfc_pkg::MEM_STEPS - 1;
    localparam int SL = fwfc_pkg::SPD_STEPS - 1;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic                            follow_side_reg,     follow_side_next;
    logic [fwfc_pkg::SPEED_W-1:0]    nominal_speed_reg,   nominal_speed_next;
    logic [fwfc_pkg::RANGE_W-1:0]    avoid_distance_reg,  avoid_distance_next;
    logic [fwfc_pkg::RANGE_W-1:0]    side_full_scale_reg, side_full_scale_next;
    logic [fwfc_pkg::RANGE_W-1:0]    diag_full_scale_reg, diag_full_scale_next;
    logic [fwfc_pkg::SPEED_W-1:0]    outer_weight_reg,    outer_weight_next;
    logic [fwfc_pkg::SPEED_W-1:0]    inner_weight_reg,    inner_weight_next;
    logic [fwfc_pkg::SPEED_W-1:0]    speed_limit_reg,     speed_limit_next;

    logic                              cfg_wr;
    logic [fwfc_pkg::REG_IDX_W-1:0]    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[fwfc_pkg::ADDR_W-1:2];

    // Register write decode.
    always_comb
    begin
        follow_side_next     = follow_side_reg;
        nominal_speed_next   = nominal_speed_reg;
        avoid_distance_next  = avoid_distance_reg;
        side_full_scale_next = side_full_scale_reg;
        diag_full_scale_next = diag_full_scale_reg;
        outer_weight_next    = outer_weight_reg;
        inner_weight_next    = inner_weight_reg;
        speed_limit_next     = speed_limit_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                fwfc_pkg::REG_FOLLOW_SIDE:     follow_side_next     = pwdata[0];
                fwfc_pkg::REG_NOMINAL_SPEED:   nominal_speed_next   = pwdata[fwfc_pkg::SPEED_W-1:0];
                fwfc_pkg::REG_AVOID_DISTANCE:  avoid_distance_next  = pwdata[fwfc_pkg::RANGE_W-1:0];
                fwfc_pkg::REG_SIDE_FULL_SCALE: side_full_scale_next = pwdata[fwfc_pkg::RANGE_W-1:0];
                fwfc_pkg::REG_DIAG_FULL_SCALE: diag_full_scale_next = pwdata[fwfc_pkg::RANGE_W-1:0];
                fwfc_pkg::REG_OUTER_WEIGHT:    outer_weight_next    = pwdata[fwfc_pkg::SPEED_W-1:0];
                fwfc_pkg::REG_INNER_WEIGHT:    inner_weight_next    = pwdata[fwfc_pkg::SPEED_W-1:0];
                fwfc_pkg::REG_SPEED_LIMIT:     speed_limit_next     = pwdata[fwfc_pkg::SPEED_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follow_side_reg     <= fwfc_pkg::RST_FOLLOW_SIDE;
            nominal_speed_reg   <= fwfc_pkg::RST_NOMINAL_SPEED;
            avoid_distance_reg  <= fwfc_pkg::RST_AVOID_DISTANCE;
            side_full_scale_reg <= fwfc_pkg::RST_SIDE_FULL_SCALE;
            diag_full_scale_reg <= fwfc_pkg::RST_DIAG_FULL_SCALE;
            outer_weight_reg    <= fwfc_pkg::RST_OUTER_WEIGHT;
            inner_weight_reg    <= fwfc_pkg::RST_INNER_WEIGHT;
            speed_limit_reg     <= fwfc_pkg::RST_SPEED_LIMIT;
        end
        else
        begin
            follow_side_reg     <= follow_side_next;
            nominal_speed_reg   <= nominal_speed_next;
            avoid_distance_reg  <= avoid_distance_next;
            side_full_scale_reg <= side_full_scale_next;
            diag_full_scale_reg <= diag_full_scale_next;
            outer_weight_reg    <= outer_weight_next;
            inner_weight_reg    <= inner_weight_next;
            speed_limit_reg     <= speed_limit_next;
        end
    end

    // Register read-back.
    always_comb
    begin
        case (cfg_idx)
            fwfc_pkg::REG_FOLLOW_SIDE:     prdata = fwfc_pkg::DATA_W'(follow_side_reg);
            fwfc_pkg::REG_NOMINAL_SPEED:   prdata = fwfc_pkg::DATA_W'(nominal_speed_reg);
            fwfc_pkg::REG_AVOID_DISTANCE:  prdata = fwfc_pkg::DATA_W'(avoid_distance_reg);
            fwfc_pkg::REG_SIDE_FULL_SCALE: prdata = fwfc_pkg::DATA_W'(side_full_scale_reg);
            fwfc_pkg::REG_DIAG_FULL_SCALE: prdata = fwfc_pkg::DATA_W'(diag_full_scale_reg);
            fwfc_pkg::REG_OUTER_WEIGHT:    prdata = fwfc_pkg::DATA_W'(outer_weight_reg);
            fwfc_pkg::REG_INNER_WEIGHT:    prdata = fwfc_pkg::DATA_W'(inner_weight_reg);
            fwfc_pkg::REG_SPEED_LIMIT:     prdata = fwfc_pkg::DATA_W'(speed_limit_reg);
            default:                       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Entry stage: clamp the ranges, decide avoidance, pick the followed side.
    // ------------------------------------------------------------------
    logic                             a_vld_reg, a_vld_next;
    logic [fwfc_pkg::ACT_W-1:0]       a_act_reg, a_act_next;
    logic [fwfc_pkg::CLAMP_W-1:0]     a_sv_reg,  a_sv_next;
    logic [fwfc_pkg::CLAMP_W-1:0]     a_dv_reg,  a_dv_next;

    assign busy = 1'b0;

    always_comb
    begin : entry_comb
        logic [fwfc_pkg::CLAMP_W-1:0] ls_c;
        logic [fwfc_pkg::CLAMP_W-1:0] ld_c;
        logic [fwfc_pkg::CLAMP_W-1:0] lf_c;
        logic [fwfc_pkg::CLAMP_W-1:0] rf_c;
        logic [fwfc_pkg::CLAMP_W-1:0] rd_c;
        logic [fwfc_pkg::CLAMP_W-1:0] rs_c;
        ls_c = fwfc_pkg::clamp_range(left_side_range);
        ld_c = fwfc_pkg::clamp_range(left_diag_range);
        lf_c = fwfc_pkg::clamp_range(left_front_range);
        rf_c = fwfc_pkg::clamp_range(right_front_range);
        rd_c = fwfc_pkg::clamp_range(right_diag_range);
        rs_c = fwfc_pkg::clamp_range(right_side_range);
        a_vld_next = start && !busy;
        // The right-front obstacle takes priority over the left-front one.
        if (fwfc_pkg::RANGE_W'(rf_c) < avoid_distance_reg)
        begin
            a_act_next = fwfc_pkg::ACT_RF;
        end
        else if (fwfc_pkg::RANGE_W'(lf_c) < avoid_distance_reg)
        begin
            a_act_next = fwfc_pkg::ACT_LF;
        end
        else
        begin
            a_act_next = fwfc_pkg::ACT_FUZZY;
        end
        a_sv_next = follow_side_reg ? rs_c : ls_c;
        a_dv_next = follow_side_reg ? rd_c : ld_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_act_reg <= a_act_next;
        a_sv_reg  <= a_sv_next;
        a_dv_reg  <= a_dv_next;
    end

    // ------------------------------------------------------------------
    // Membership dividers: value * 2^14 / full scale, one quotient bit per
    // stage for the side and the diagonal sensor side by side.
    // ------------------------------------------------------------------
    logic                               ms_vld_reg   [fwfc_pkg::MEM_STEPS];
    logic                               ms_vld_next  [fwfc_pkg::MEM_STEPS];
    logic [fwfc_pkg::ACT_W-1:0]         ms_act_reg   [fwfc_pkg::MEM_STEPS];
    logic [fwfc_pkg::ACT_W-1:0]         ms_act_next  [fwfc_pkg::MEM_STEPS];
    logic                               ms_sat_s_reg [fwfc_pkg::MEM_STEPS];
    logic                               ms_sat_s_next[fwfc_pkg::MEM_STEPS];
    logic                               ms_sat_d_reg [fwfc_pkg::MEM_STEPS];
    logic                               ms_sat_d_next[fwfc_pkg::MEM_STEPS];
    logic [fwfc_pkg::MEM_REM_W-1:0]     ms_rem_s_reg [fwfc_pkg::MEM_STEPS];
    logic [fwfc_pkg::MEM_REM_W-1:0]     ms_rem_s_next[fwfc_pkg::MEM_STEPS];
    logic [fwfc_pkg::MEM_REM_W-1:0]     ms_rem_d_reg [fwfc_pkg::MEM_STEPS];
    logic [fwfc_pkg::MEM_REM_W-1:0]     ms_rem_d_next[fwfc_pkg::MEM_STEPS];
    logic [fwfc_pkg::MEMB_W-1:0]        ms_q_s_reg   [fwfc_pkg::MEM_STEPS];
    logic [fwfc_pkg::MEMB_W-1:0]        ms_q_s_next  [fwfc_pkg::MEM_STEPS];
    logic [fwfc_pkg::MEMB_W-1:0]        ms_q_d_reg   [fwfc_pkg::MEM_STEPS];
    logic [fwfc_pkg::MEMB_W-1:0]        ms_q_d_next  [fwfc_pkg::MEM_STEPS];

    always_comb
    begin : memb_comb
        logic [fwfc_pkg::RANGE_W-1:0]   fs_eff;
        logic [fwfc_pkg::RANGE_W-1:0]   fd_eff;
        logic [fwfc_pkg::MEM_REM_W-1:0] rem_s;
        logic [fwfc_pkg::MEM_REM_W-1:0] rem_d;
        logic [fwfc_pkg::MEM_REM_W-1:0] dsh_s;
        logic [fwfc_pkg::MEM_REM_W-1:0] dsh_d;
        logic [fwfc_pkg::MEMB_W-1:0]    q_s;
        logic [fwfc_pkg::MEMB_W-1:0]    q_d;
        logic                           ge_s;
        logic                           ge_d;
        // A zero full scale counts as a full scale of one.
        fs_eff = (side_full_scale_reg == '0) ? fwfc_pkg::RANGE_W'(1) : side_full_scale_reg;
        fd_eff = (diag_full_scale_reg == '0) ? fwfc_pkg::RANGE_W'(1) : diag_full_scale_reg;
        for (int j = 0; j < fwfc_pkg::MEM_STEPS; j++)
        begin
            if (j == 0)
            begin
                rem_s = fwfc_pkg::MEM_REM_W'({a_sv_reg, {fwfc_pkg::Q_FRAC{1'b0}}});
                rem_d = fwfc_pkg::MEM_REM_W'({a_dv_reg, {fwfc_pkg::Q_FRAC{1'b0}}});
                q_s   = '0;
                q_d   = '0;
                ms_vld_next[j] = a_vld_reg;
                ms_act_next[j] = a_act_reg;
                // The quotient overflows 15 bits exactly when value >= 2 * full scale.
                ms_sat_s_next[j] = (fwfc_pkg::RANGE_W + 1)'(a_sv_reg) >= {fs_eff, 1'b0};
                ms_sat_d_next[j] = (fwfc_pkg::RANGE_W + 1)'(a_dv_reg) >= {fd_eff, 1'b0};
            end
            else
            begin
                rem_s = ms_rem_s_reg[j-1];
                rem_d = ms_rem_d_reg[j-1];
                q_s   = ms_q_s_reg[j-1];
                q_d   = ms_q_d_reg[j-1];
                ms_vld_next[j]   = ms_vld_reg[j-1];
                ms_act_next[j]   = ms_act_reg[j-1];
                ms_sat_s_next[j] = ms_sat_s_reg[j-1];
                ms_sat_d_next[j] = ms_sat_d_reg[j-1];
            end
            dsh_s = fwfc_pkg::MEM_REM_W'(fs_eff) << (fwfc_pkg::MEM_STEPS - 1 - j);
            dsh_d = fwfc_pkg::MEM_REM_W'(fd_eff) << (fwfc_pkg::MEM_STEPS - 1 - j);
            ge_s  = rem_s >= dsh_s;
            ge_d  = rem_d >= dsh_d;
            ms_rem_s_next[j] = ge_s ? (rem_s - dsh_s) : rem_s;
            ms_rem_d_next[j] = ge_d ? (rem_d - dsh_d) : rem_d;
            ms_q_s_next[j]   = {q_s[fwfc_pkg::MEMB_W-2:0], ge_s};
            ms_q_d_next[j]   = {q_d[fwfc_pkg::MEMB_W-2:0], ge_d};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < fwfc_pkg::MEM_STEPS; j++)
            begin
                ms_vld_reg[j] <= 1'b0;
            end
        end
        else
        begin
            for (int j = 0; j < fwfc_pkg::MEM_STEPS; j++)
            begin
                ms_vld_reg[j] <= ms_vld_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < fwfc_pkg::MEM_STEPS; j++)
        begin
            ms_act_reg[j]   <= ms_act_next[j];
            ms_sat_s_reg[j] <= ms_sat_s_next[j];
            ms_sat_d_reg[j] <= ms_sat_d_next[j];
            ms_rem_s_reg[j] <= ms_rem_s_next[j];
            ms_rem_d_reg[j] <= ms_rem_d_next[j];
            ms_q_s_reg[j]   <= ms_q_s_next[j];
            ms_q_d_reg[j]   <= ms_q_d_next[j];
        end
    end

    // ------------------------------------------------------------------
    // Rule stage: memberships and the four rule strengths by min.
    // ------------------------------------------------------------------
    logic                                 b_vld_reg, b_vld_next;
    logic [fwfc_pkg::ACT_W-1:0]           b_act_reg, b_act_next;
    logic signed [fwfc_pkg::RULE_W-1:0]   rule_reg  [fwfc_pkg::RULES];
    logic signed [fwfc_pkg::RULE_W-1:0]   rule_next [fwfc_pkg::RULES];

    always_comb
    begin : rule_comb
        logic [fwfc_pkg::MEMB_W-1:0]        hs;
        logic [fwfc_pkg::MEMB_W-1:0]        hd;
        logic signed [fwfc_pkg::RULE_W-1:0] hs_q;
        logic signed [fwfc_pkg::RULE_W-1:0] hd_q;
        logic signed [fwfc_pkg::RULE_W-1:0] lo_s;
        logic signed [fwfc_pkg::RULE_W-1:0] lo_d;
        hs   = ms_sat_s_reg[ML] ? fwfc_pkg::Q_MAX : ms_q_s_reg[ML];
        hd   = ms_sat_d_reg[ML] ? fwfc_pkg::Q_MAX : ms_q_d_reg[ML];
        hs_q = $signed({1'b0, hs});
        hd_q = $signed({1'b0, hd});
        lo_s = fwfc_pkg::Q_ONE - hs_q;
        lo_d = fwfc_pkg::Q_ONE - hd_q;
        rule_next[0] = fwfc_pkg::rule_min(lo_s, hd_q);
        rule_next[1] = fwfc_pkg::rule_min(hs_q, hd_q);
        rule_next[2] = fwfc_pkg::rule_min(lo_s, lo_d);
        rule_next[3] = fwfc_pkg::rule_min(hs_q, lo_d);
        b_vld_next   = ms_vld_reg[ML];
        b_act_next   = ms_act_reg[ML];
    end

    // ------------------------------------------------------------------
    // Product stage: weight times strength, and the strength sum.
    // ------------------------------------------------------------------
    logic                                 c_vld_reg, c_vld_next;
    logic [fwfc_pkg::ACT_W-1:0]           c_act_reg, c_act_next;
    logic signed [fwfc_pkg::PROD_W-1:0]   prod_reg  [fwfc_pkg::RULES];
    logic signed [fwfc_pkg::PROD_W-1:0]   prod_next [fwfc_pkg::RULES];
    logic signed [fwfc_pkg::SUM_W-1:0]    c_sum_reg, c_sum_next;

    always_comb
    begin : prod_comb
        logic signed [fwfc_pkg::SPEED_W:0] wo;
        logic signed [fwfc_pkg::SPEED_W:0] wi;
        wo = $signed({1'b0, outer_weight_reg});
        wi = $signed({1'b0, inner_weight_reg});
        prod_next[0] = fwfc_pkg::PROD_W'(wo) * fwfc_pkg::PROD_W'(rule_reg[0]);
        prod_next[1] = fwfc_pkg::PROD_W'(wi) * fwfc_pkg::PROD_W'(rule_reg[1]);
        prod_next[2] = fwfc_pkg::PROD_W'(wi) * fwfc_pkg::PROD_W'(rule_reg[2]);
        prod_next[3] = fwfc_pkg::PROD_W'(wo) * fwfc_pkg::PROD_W'(rule_reg[3]);
        c_sum_next   = fwfc_pkg::SUM_W'(rule_reg[0]) + fwfc_pkg::SUM_W'(rule_reg[1])
                     + fwfc_pkg::SUM_W'(rule_reg[2]) + fwfc_pkg::SUM_W'(rule_reg[3]);
        c_vld_next   = b_vld_reg;
        c_act_next   = b_act_reg;
    end

    // ------------------------------------------------------------------
    // Sum stage: signed weighted sum N and the base nominal * S.
    // ------------------------------------------------------------------
    logic                                 d_vld_reg,  d_vld_next;
    logic [fwfc_pkg::ACT_W-1:0]           d_act_reg,  d_act_next;
    logic signed [fwfc_pkg::N_W-1:0]      d_n_reg,    d_n_next;
    logic signed [fwfc_pkg::NUM_W-1:0]    d_base_reg, d_base_next;
    logic [fwfc_pkg::DIV_W-1:0]           d_div_reg,  d_div_next;
    logic                                 d_spos_reg, d_spos_next;

    always_comb
    begin : sum_comb
        logic signed [fwfc_pkg::N_W-1:0]     n_raw;
        logic signed [fwfc_pkg::SPEED_W:0]   nom_s;
        n_raw = fwfc_pkg::N_W'(prod_reg[0]) + fwfc_pkg::N_W'(prod_reg[1])
              - fwfc_pkg::N_W'(prod_reg[2]) - fwfc_pkg::N_W'(prod_reg[3]);
        nom_s = $signed({1'b0, nominal_speed_reg});
        // Right-side following mirrors the rule weights.
        d_n_next    = follow_side_reg ? -n_raw : n_raw;
        d_base_next = fwfc_pkg::NUM_W'(nom_s) * fwfc_pkg::NUM_W'(c_sum_reg);
        d_div_next  = c_sum_reg[fwfc_pkg::DIV_W-1:0];
        d_spos_next = !c_sum_reg[fwfc_pkg::SUM_W-1] && (c_sum_reg != '0);
        d_vld_next  = c_vld_reg;
        d_act_next  = c_act_reg;
    end

    // ------------------------------------------------------------------
    // Numerator stage: nominal * S - N for the left wheel, + N for the right.
    // ------------------------------------------------------------------
    logic                                 e_vld_reg,   e_vld_next;
    logic [fwfc_pkg::ACT_W-1:0]           e_act_reg,   e_act_next;
    logic signed [fwfc_pkg::NUM_W-1:0]    e_num_l_reg, e_num_l_next;
    logic signed [fwfc_pkg::NUM_W-1:0]    e_num_r_reg, e_num_r_next;
    logic [fwfc_pkg::DIV_W-1:0]           e_div_reg,   e_div_next;
    logic                                 e_spos_reg,  e_spos_next;

    always_comb
    begin
        e_num_l_next = d_base_reg - fwfc_pkg::NUM_W'(d_n_reg);
        e_num_r_next = d_base_reg + fwfc_pkg::NUM_W'(d_n_reg);
        e_div_next   = d_div_reg;
        e_spos_next  = d_spos_reg;
        e_vld_next   = d_vld_reg;
        e_act_next   = d_act_reg;
    end

    // Valid bits of the middle stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= b_vld_next;
            c_vld_reg <= c_vld_next;
            d_vld_reg <= d_vld_next;
            e_vld_reg <= e_vld_next;
        end
    end

    // Payload of the middle stages.
    always_ff @(posedge clk)
    begin
        b_act_reg   <= b_act_next;
        c_act_reg   <= c_act_next;
        c_sum_reg   <= c_sum_next;
        d_act_reg   <= d_act_next;
        d_n_reg     <= d_n_next;
        d_base_reg  <= d_base_next;
        d_div_reg   <= d_div_next;
        d_spos_reg  <= d_spos_next;
        e_act_reg   <= e_act_next;
        e_num_l_reg <= e_num_l_next;
        e_num_r_reg <= e_num_r_next;
        e_div_reg   <= e_div_next;
        e_spos_reg  <= e_spos_next;
        for (int i = 0; i < fwfc_pkg::RULES; i++)
        begin
            rule_reg[i] <= rule_next[i];
            prod_reg[i] <= prod_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Speed dividers: numerator / S for both wheels, one quotient bit per
    // stage. Only ten bits are needed since the speed is clamped to the speed limit, at most 1023.
    // ------------------------------------------------------------------
    logic                               sd_vld_reg   [fwfc_pkg::SPD_STEPS];
    logic                               sd_vld_next  [fwfc_pkg::SPD_STEPS];
    logic [fwfc_pkg::ACT_W-1:0]         sd_act_reg   [fwfc_pkg::SPD_STEPS];
    logic [fwfc_pkg::ACT_W-1:0]         sd_act_next  [fwfc_pkg::SPD_STEPS];
    logic                               sd_spos_reg  [fwfc_pkg::SPD_STEPS];
    logic                               sd_spos_next [fwfc_pkg::SPD_STEPS];
    logic                               sd_neg_l_reg [fwfc_pkg::SPD_STEPS];
    logic                               sd_neg_l_next[fwfc_pkg::SPD_STEPS];
    logic                               sd_neg_r_reg [fwfc_pkg::SPD_STEPS];
    logic                               sd_neg_r_next[fwfc_pkg::SPD_STEPS];
    logic                               sd_sat_l_reg [fwfc_pkg::SPD_STEPS];
    logic                               sd_sat_l_next[fwfc_pkg::SPD_STEPS];
    logic                               sd_sat_r_reg [fwfc_pkg::SPD_STEPS];
    logic                               sd_sat_r_next[fwfc_pkg::SPD_STEPS];
    logic [fwfc_pkg::DIV_W-1:0]         sd_div_reg   [fwfc_pkg::SPD_STEPS];
    logic [fwfc_pkg::DIV_W-1:0]         sd_div_next  [fwfc_pkg::SPD_STEPS];
    logic [fwfc_pkg::SPD_REM_W-1:0]     sd_rem_l_reg [fwfc_pkg::SPD_STEPS];
    logic [fwfc_pkg::SPD_REM_W-1:0]     sd_rem_l_next[fwfc_pkg::SPD_STEPS];
    logic [fwfc_pkg::SPD_REM_W-1:0]     sd_rem_r_reg [fwfc_pkg::SPD_STEPS];
    logic [fwfc_pkg::SPD_REM_W-1:0]     sd_rem_r_next[fwfc_pkg::SPD_STEPS];
    logic [fwfc_pkg::SPEED_W-1:0]       sd_q_l_reg   [fwfc_pkg::SPD_STEPS];
    logic [fwfc_pkg::SPEED_W-1:0]       sd_q_l_next  [fwfc_pkg::SPD_STEPS];
    logic [fwfc_pkg::SPEED_W-1:0]       sd_q_r_reg   [fwfc_pkg::SPD_STEPS];
    logic [fwfc_pkg::SPEED_W-1:0]       sd_q_r_next  [fwfc_pkg::SPD_STEPS];

    always_comb
    begin : speed_div_comb
        logic [fwfc_pkg::SPD_REM_W-1:0] rem_l;
        logic [fwfc_pkg::SPD_REM_W-1:0] rem_r;
        logic [fwfc_pkg::SPD_REM_W-1:0] dsh;
        logic [fwfc_pkg::SPD_REM_W-1:0] dtop;
        logic [fwfc_pkg::SPEED_W-1:0]   q_l;
        logic [fwfc_pkg::SPEED_W-1:0]   q_r;
        logic [fwfc_pkg::DIV_W-1:0]     dv;
        logic                           ge_l;
        logic                           ge_r;
        for (int j = 0; j < fwfc_pkg::SPD_STEPS; j++)
        begin
            if (j == 0)
            begin
                rem_l = e_num_l_reg[fwfc_pkg::SPD_REM_W-1:0];
                rem_r = e_num_r_reg[fwfc_pkg::SPD_REM_W-1:0];
                q_l   = '0;
                q_r   = '0;
                dv    = e_div_reg;
                dtop  = fwfc_pkg::SPD_REM_W'(e_div_reg) << fwfc_pkg::SPD_STEPS;
                sd_vld_next[j]   = e_vld_reg;
                sd_act_next[j]   = e_act_reg;
                sd_spos_next[j]  = e_spos_reg;
                sd_neg_l_next[j] = e_num_l_reg[fwfc_pkg::NUM_W-1];
                sd_neg_r_next[j] = e_num_r_reg[fwfc_pkg::NUM_W-1];
                // A quotient of 1024 or more only ever meets the speed limit.
                sd_sat_l_next[j] = rem_l >= dtop;
                sd_sat_r_next[j] = rem_r >= dtop;
            end
            else
            begin
                rem_l = sd_rem_l_reg[j-1];
                rem_r = sd_rem_r_reg[j-1];
                q_l   = sd_q_l_reg[j-1];
                q_r   = sd_q_r_reg[j-1];
                dv    = sd_div_reg[j-1];
                dtop  = '0;
                sd_vld_next[j]   = sd_vld_reg[j-1];
                sd_act_next[j]   = sd_act_reg[j-1];
                sd_spos_next[j]  = sd_spos_reg[j-1];
                sd_neg_l_next[j] = sd_neg_l_reg[j-1];
                sd_neg_r_next[j] = sd_neg_r_reg[j-1];
                sd_sat_l_next[j] = sd_sat_l_reg[j-1];
                sd_sat_r_next[j] = sd_sat_r_reg[j-1];
            end
            dsh  = fwfc_pkg::SPD_REM_W'(dv) << (fwfc_pkg::SPD_STEPS - 1 - j);
            ge_l = rem_l >= dsh;
            ge_r = rem_r >= dsh;
            sd_div_next[j]   = dv;
            sd_rem_l_next[j] = ge_l ? (rem_l - dsh) : rem_l;
            sd_rem_r_next[j] = ge_r ? (rem_r - dsh) : rem_r;
            sd_q_l_next[j]   = {q_l[fwfc_pkg::SPEED_W-2:0], ge_l};
            sd_q_r_next[j]   = {q_r[fwfc_pkg::SPEED_W-2:0], ge_r};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < fwfc_pkg::SPD_STEPS; j++)
            begin
                sd_vld_reg[j] <= 1'b0;
            end
        end
        else
        begin
            for (int j = 0; j < fwfc_pkg::SPD_STEPS; j++)
            begin
                sd_vld_reg[j] <= sd_vld_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < fwfc_pkg::SPD_STEPS; j++)
        begin
            sd_act_reg[j]   <= sd_act_next[j];
            sd_spos_reg[j]  <= sd_spos_next[j];
            sd_neg_l_reg[j] <= sd_neg_l_next[j];
            sd_neg_r_reg[j] <= sd_neg_r_next[j];
            sd_sat_l_reg[j] <= sd_sat_l_next[j];
            sd_sat_r_reg[j] <= sd_sat_r_next[j];
            sd_div_reg[j]   <= sd_div_next[j];
            sd_rem_l_reg[j] <= sd_rem_l_next[j];
            sd_rem_r_reg[j] <= sd_rem_r_next[j];
            sd_q_l_reg[j]   <= sd_q_l_next[j];
            sd_q_r_reg[j]   <= sd_q_r_next[j];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: select the avoidance, cruise or fuzzy speeds and strobe the beat.
    // ------------------------------------------------------------------
    logic                           done_reg,        done_next;
    logic [fwfc_pkg::SPEED_W-1:0]   left_speed_reg,  left_speed_next;
    logic [fwfc_pkg::SPEED_W-1:0]   right_speed_reg, right_speed_next;
    logic [fwfc_pkg::ACT_W-1:0]     action_reg,      action_next;

    always_comb
    begin : out_comb
        logic [fwfc_pkg::SPEED_W-1:0] turn_spd;
        logic [fwfc_pkg::SPEED_W-1:0] cruise_spd;
        turn_spd   = fwfc_pkg::speed_min(nominal_speed_reg >> 2, speed_limit_reg);
        cruise_spd = fwfc_pkg::speed_min(nominal_speed_reg, speed_limit_reg);
        done_next  = sd_vld_reg[SL];
        case (sd_act_reg[SL])
            fwfc_pkg::ACT_RF:
            begin
                left_speed_next  = '0;
                right_speed_next = turn_spd;
                action_next      = fwfc_pkg::ACT_RF;
            end
            fwfc_pkg::ACT_LF:
            begin
                left_speed_next  = turn_spd;
                right_speed_next = '0;
                action_next      = fwfc_pkg::ACT_LF;
            end
            default:
            begin
                if (!sd_spos_reg[SL])
                begin
                    // Rule strength sum not positive: cruise straight.
                    left_speed_next  = cruise_spd;
                    right_speed_next = cruise_spd;
                    action_next      = fwfc_pkg::ACT_ZERO;
                end
                else
                begin
                    left_speed_next  = fwfc_pkg::fuzzy_speed(sd_neg_l_reg[SL], sd_sat_l_reg[SL],
                                                             sd_q_l_reg[SL], speed_limit_reg);
                    right_speed_next = fwfc_pkg::fuzzy_speed(sd_neg_r_reg[SL], sd_sat_r_reg[SL],
                                                             sd_q_r_reg[SL], speed_limit_reg);
                    action_next      = fwfc_pkg::ACT_FUZZY;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_speed_reg  <= left_speed_next;
        right_speed_reg <= right_speed_next;
        action_reg      <= action_next;
    end

    assign done        = done_reg;
    assign left_speed  = left_speed_reg;
    assign right_speed = right_speed_reg;
    assign action      = action_reg;

`ifndef SYNTHESIS
    // Every accepted tick produces its result beat.
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(fwfc_pkg::PIPE_LATENCY) done)
        else $error("result beat missing after an accepted tick");

    // A result beat only ever follows an accepted tick.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, fwfc_pkg::PIPE_LATENCY))
        else $error("result beat without an accepted tick");

    // Right-front avoidance stops the left wheel.
    a_rf_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (action == fwfc_pkg::ACT_RF)) |-> (left_speed == '0))
        else $error("right-front avoidance with a moving left wheel");

    // Left-front avoidance stops the right wheel.
    a_lf_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (action == fwfc_pkg::ACT_LF)) |-> (right_speed == '0))
        else $error("left-front avoidance with a moving right wheel");
`endif

endmodule
